// ===== design/sip_pkg.sv =====
package sip_pkg;

  localparam int WORD_W  = 64;
  localparam int COUNT_W = 4;
  localparam int ROUND_W = 4;
  localparam int LEN_W   = 8;
  localparam int CFG_IDX_W = 2;

  localparam int FIFO_DEPTH_DEFAULT = 2;

  // SipHash initialization constants
  localparam logic [WORD_W-1:0] SIP_C0 = 64'h736f6d6570736575;
  localparam logic [WORD_W-1:0] SIP_C1 = 64'h646f72616e646f6d;
  localparam logic [WORD_W-1:0] SIP_C2 = 64'h6c7967656e657261;
  localparam logic [WORD_W-1:0] SIP_C3 = 64'h7465646279746573;
  localparam logic [WORD_W-1:0] SIP_FIN_XOR = 64'h00000000000000ff;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COMP_ROUND = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FIN_ROUND  = 2'd3;

  localparam logic [ROUND_W-1:0] COMP_ROUNDS_RESET = 4'd2;
  localparam logic [ROUND_W-1:0] FIN_ROUNDS_RESET  = 4'd4;

  typedef logic [3:0][WORD_W-1:0] chain_t;

  // one classified message word, handed from front to back
  typedef struct packed {
    logic [WORD_W-1:0] word;   // full word to compress
    logic [WORD_W-1:0] pad;    // pad word with length byte
    logic              start;  // first word of a message
    logic              last;   // final word, finalize after
    logic              full;   // word itself is compressed
  } job_t;

  typedef struct packed {
    logic [WORD_W-1:0]  key_low;
    logic [WORD_W-1:0]  key_high;
    logic [ROUND_W-1:0] comp_rounds;
    logic [ROUND_W-1:0] fin_rounds;
  } cfg_t;

endpackage

// ===== design/sip_if.sv =====
interface sip_in_if import sip_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [WORD_W-1:0]  message_word;
  logic [COUNT_W-1:0] byte_count;
  logic               last_word;

  modport source (output valid, message_word, byte_count, last_word, input ready);
  modport sink (input valid, message_word, byte_count, last_word, output ready);
endinterface

interface sip_out_if import sip_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] digest;

  modport source (output valid, digest, input ready);
  modport sink (input valid, digest, output ready);
endinterface

// ===== design/siphash_keyed_hash_unit.sv =====
// channel   | dir | payload                                 | notes
// msg_in    | in  | message_word, byte_count, last_word     | one message word per transfer
// hash_out  | out | digest                                  | one transfer per last word
// cfg_*     | in  | cfg_index, cfg_data                     | write-only, one cycle
//
// The back end runs one SipRound per cycle unless a finished digest is held back: a
// non-last word is compressed once; a last word compresses the pad word and then
// finalizes, and first compresses the word itself when it carries eight bytes or more.
// Reset is synchronous and clears the queue, message tracking, the output
// register and sets the config registers to their defaults.
// The queue lets words be taken while the back end is busy; a digest that is
// not taken holds the back end at the end of finalization.
module siphash_keyed_hash_unit import sip_pkg::*; #(
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  sip_in_if.sink               msg_in,
  sip_out_if.source            hash_out,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data
);

  cfg_t cfg;
  logic push;
  job_t push_job;
  logic full;
  logic pop;
  job_t head;
  logic empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.key_low     <= '0;
      cfg.key_high    <= '0;
      cfg.comp_rounds <= COMP_ROUNDS_RESET;
      cfg.fin_rounds  <= FIN_ROUNDS_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_KEY_LOW:    cfg.key_low     <= cfg_data;
        REG_KEY_HIGH:   cfg.key_high    <= cfg_data;
        REG_COMP_ROUND: cfg.comp_rounds <= cfg_data[ROUND_W-1:0];
        REG_FIN_ROUND:  cfg.fin_rounds  <= cfg_data[ROUND_W-1:0];
        default: ;
      endcase
    end
  end

  sip_front u_front (
    .clk      (clk),
    .rst      (rst),
    .msg_in   (msg_in),
    .full     (full),
    .push     (push),
    .push_job (push_job)
  );

  sip_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .head     (head),
    .empty    (empty)
  );

  sip_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .head     (head),
    .empty    (empty),
    .pop      (pop),
    .hash_out (hash_out)
  );

endmodule

// ===== design/sip_front.sv =====
module sip_front import sip_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  sip_in_if.sink   msg_in,
  input  logic     full,
  output logic     push,
  output job_t     push_job
);

  logic [LEN_W-1:0] len;
  logic             open;

  logic [LEN_W-1:0]  base_len;
  logic [LEN_W-1:0]  len_next;
  logic              is_full;
  logic [WORD_W-1:0] masked;

  assign msg_in.ready = !full;
  assign push = msg_in.valid && !full;

  always_comb begin
    // a non-last word always counts as eight bytes; counts above eight saturate
    is_full  = !msg_in.last_word || msg_in.byte_count[3];
    base_len = open ? len : '0;
    if (is_full) begin
      len_next = base_len + LEN_W'(8);
    end else begin
      len_next = base_len + LEN_W'(msg_in.byte_count[2:0]);
    end
    for (int i = 0; i < 8; i++) begin
      masked[i*8 +: 8] = (i < int'(msg_in.byte_count[2:0])) ? msg_in.message_word[i*8 +: 8]
                                                            : 8'h00;
    end
    push_job.word  = msg_in.message_word;
    push_job.pad   = (is_full ? '0 : masked) | {len_next, {(WORD_W-LEN_W){1'b0}}};
    push_job.start = !open;
    push_job.last  = msg_in.last_word;
    push_job.full  = is_full;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      open <= 1'b0;
      len  <= '0;
    end else if (push) begin
      open <= !msg_in.last_word;
      len  <= len_next;
    end
  end

endmodule

// ===== design/sip_fifo.sv =====
module sip_fifo import sip_pkg::*; #(
  parameter int DEPTH = FIFO_DEPTH_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output job_t head,
  output logic empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  logic do_push;
  logic do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH-1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH-1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// ===== design/sip_back.sv =====
module sip_back import sip_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  job_t      head,
  input  logic      empty,
  output logic      pop,
  sip_out_if.source hash_out
);

  localparam logic [1:0] PH_WORD  = 2'd0;
  localparam logic [1:0] PH_PAD   = 2'd1;
  localparam logic [1:0] PH_FINAL = 2'd2;

  function automatic logic [WORD_W-1:0] rotl(logic [WORD_W-1:0] x, int s);
    return (x << s) | (x >> (WORD_W - s));
  endfunction

  // xor in, optional single SipRound, xor out
  function automatic chain_t sip_step(chain_t v, logic [WORD_W-1:0] m_in,
                                      logic [WORD_W-1:0] f2, logic do_round,
                                      logic [WORD_W-1:0] m_out);
    logic [WORD_W-1:0] a, b, c, d;
    chain_t r;
    a = v[0];
    b = v[1];
    c = v[2] ^ f2;
    d = v[3] ^ m_in;
    if (do_round) begin
      a = a + b; b = rotl(b, 13); b = b ^ a; a = rotl(a, 32);
      c = c + d; d = rotl(d, 16); d = d ^ c;
      a = a + d; d = rotl(d, 21); d = d ^ a;
      c = c + b; b = rotl(b, 17); b = b ^ c; c = rotl(c, 32);
    end
    r[0] = a ^ m_out;
    r[1] = b;
    r[2] = c;
    r[3] = d;
    return r;
  endfunction

  chain_t             v;
  job_t               job;
  logic [1:0]         phase;
  logic               busy;
  logic               entering;
  logic [ROUND_W-1:0] cnt;
  logic               out_valid;
  logic [WORD_W-1:0]  digest;

  job_t               job_cur;
  chain_t             base;
  chain_t             v_next;
  logic [1:0]         phase_cur;
  logic               enter_cur;
  logic               act;
  logic               done;
  logic               stall;
  logic               advance;
  logic [WORD_W-1:0]  msg;
  logic [WORD_W-1:0]  m_in;
  logic [WORD_W-1:0]  f2;
  logic [WORD_W-1:0]  m_out;
  logic               do_round;
  logic [ROUND_W-1:0] rounds;
  logic [ROUND_W-1:0] cnt_next;
  chain_t             init;

  assign init = {cfg.key_high ^ SIP_C3, cfg.key_low ^ SIP_C2,
                 cfg.key_high ^ SIP_C1, cfg.key_low ^ SIP_C0};

  always_comb begin
    if (!busy) begin
      act       = !empty;
      job_cur   = head;
      base      = head.start ? init : v;
      phase_cur = head.full ? PH_WORD : PH_PAD;
      enter_cur = 1'b1;
    end else begin
      act       = 1'b1;
      job_cur   = job;
      base      = v;
      phase_cur = phase;
      enter_cur = entering;
    end

    case (phase_cur)
      PH_WORD: msg = job_cur.word;
      PH_PAD:  msg = job_cur.pad;
      default: msg = '0;
    endcase
    rounds = (phase_cur == PH_FINAL) ? cfg.fin_rounds : cfg.comp_rounds;

    if (enter_cur) begin
      m_in     = msg;
      f2       = (phase_cur == PH_FINAL) ? SIP_FIN_XOR : '0;
      do_round = (rounds != '0);
      done     = (rounds <= ROUND_W'(1));
      cnt_next = rounds - ROUND_W'(1);
    end else begin
      m_in     = '0;
      f2       = '0;
      do_round = 1'b1;
      done     = (cnt == ROUND_W'(1));
      cnt_next = cnt - ROUND_W'(1);
    end
    m_out = done ? msg : '0;

    // hold the finished digest back until the output register frees up
    stall   = act && done && (phase_cur == PH_FINAL) && out_valid && !hash_out.ready;
    advance = act && !stall;
    pop     = !busy && !empty && !stall;
    v_next  = sip_step(base, m_in, f2, do_round, m_out);
  end

  assign hash_out.valid  = out_valid;
  assign hash_out.digest = digest;

  always_ff @(posedge clk) begin
    if (advance) begin
      v <= v_next;
      if (!busy) begin
        job <= head;
      end
      if (!done) begin
        cnt <= cnt_next;
      end
      if (done && phase_cur == PH_FINAL) begin
        digest <= v_next[0] ^ v_next[1] ^ v_next[2] ^ v_next[3];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      entering  <= 1'b0;
      phase     <= PH_WORD;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && hash_out.ready) begin
        out_valid <= 1'b0;
      end
      if (advance) begin
        if (!done) begin
          busy     <= 1'b1;
          entering <= 1'b0;
          phase    <= phase_cur;
        end else begin
          case (phase_cur)
            PH_WORD: begin
              busy     <= job_cur.last;
              entering <= 1'b1;
              phase    <= PH_PAD;
            end
            PH_PAD: begin
              busy     <= 1'b1;
              entering <= 1'b1;
              phase    <= PH_FINAL;
            end
            default: begin
              busy      <= 1'b0;
              entering  <= 1'b0;
              phase     <= PH_WORD;
              out_valid <= 1'b1;
            end
          endcase
        end
      end
    end
  end

endmodule

// ===== design/sip_checker.sv =====
module sip_checker import sip_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [WORD_W-1:0] digest
);

  // queue is empty right after reset
  a_ready_after_reset: assert property (@(posedge clk) rst |=> in_ready)
    else $error("input not ready after reset");

  a_no_out_after_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("digest valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("digest dropped before transfer");

  a_digest_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(digest))
    else $error("digest changed while stalled");

endmodule

bind siphash_keyed_hash_unit sip_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (msg_in.ready),
  .out_valid (hash_out.valid),
  .out_ready (hash_out.ready),
  .digest    (hash_out.digest)
);

// ===== tb/siphash_keyed_hash_unit_tb.sv =====
`timescale 1ns / 1ps

module siphash_keyed_hash_unit_tb;
  import sip_pkg::*;

  localparam int GAP_MAX       = 18;
  localparam int SETTLE_CYCLES = 100;
  localparam int LONG_HOLD     = 300;
  localparam int ITEM_TARGET   = 1000;
  localparam int DIR_ROWS      = 27;

  localparam logic [WORD_W-1:0] ONES = '1;

  typedef enum logic {ROW_WORD, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [WORD_W-1:0]  data;
    logic [COUNT_W-1:0] cnt;
    logic               last;
    logic               known;
    logic [WORD_W-1:0]  digest;
  } row_t;

  // kind, reg index, data, byte count, last, digest known, digest
  row_t directed [DIR_ROWS] = '{
    // reset config: key zero, 2/4 rounds
    '{ROW_WORD, REG_KEY_LOW, ONES, 4'd0, 1'b1, 1'b0, 64'h0},
    '{ROW_WORD, REG_KEY_LOW, ONES, 4'd8, 1'b0, 1'b0, 64'h0},
    '{ROW_WORD, REG_KEY_LOW, ONES, 4'd8, 1'b1, 1'b0, 64'h0},
    '{ROW_WORD, REG_KEY_LOW, 64'h0123456789abcdef, 4'd15, 1'b1, 1'b0, 64'h0},
    '{ROW_WORD, REG_KEY_LOW, 64'hdeadbeefcafef00d, 4'd3, 1'b0, 1'b0, 64'h0},
    '{ROW_WORD, REG_KEY_LOW, 64'h00000000000000a5, 4'd5, 1'b1, 1'b0, 64'h0},
    // published SipHash-2-4 key 00..0f
    '{ROW_REG, REG_KEY_LOW, 64'h0706050403020100, 4'd0, 1'b0, 1'b0, 64'h0},
    '{ROW_REG, REG_KEY_HIGH, 64'h0f0e0d0c0b0a0908, 4'd0, 1'b0, 1'b0, 64'h0},
    '{ROW_REG, REG_COMP_ROUND, 64'd2, 4'd0, 1'b0, 1'b0, 64'h0},
    '{ROW_REG, REG_FIN_ROUND, 64'd4, 4'd0, 1'b0, 1'b0, 64'h0},
    '{ROW_WORD, REG_KEY_LOW, 64'h0, 4'd0, 1'b1, 1'b1, 64'h726fdb47dd0e0e31},
    '{ROW_WORD, REG_KEY_LOW, 64'h0706050403020100, 4'd8, 1'b0, 1'b0, 64'h0},
    // top byte is outside the count and must be masked
    '{ROW_WORD, REG_KEY_LOW, 64'hff0e0d0c0b0a0908, 4'd7, 1'b1, 1'b1, 64'ha129ca6149be45e5},
    // zero rounds, all-ones key
    '{ROW_REG, REG_KEY_LOW, ONES, 4'd0, 1'b0, 1'b0, 64'h0},
    '{ROW_REG, REG_KEY_HIGH, ONES, 4'd0, 1'b0, 1'b0, 64'h0},
    '{ROW_REG, REG_COMP_ROUND, 64'd0, 4'd0, 1'b0, 1'b0, 64'h0},
    '{ROW_REG, REG_FIN_ROUND, 64'd0, 4'd0, 1'b0, 1'b0, 64'h0},
    '{ROW_WORD, REG_KEY_LOW, ONES, 4'd8, 1'b1, 1'b0, 64'h0},
    '{ROW_WORD, REG_KEY_LOW, 64'h0000000000000080, 4'd1, 1'b1, 1'b0, 64'h0},
    // max rounds
    '{ROW_REG, REG_COMP_ROUND, 64'd15, 4'd0, 1'b0, 1'b0, 64'h0},
    '{ROW_REG, REG_FIN_ROUND, 64'd15, 4'd0, 1'b0, 1'b0, 64'h0},
    '{ROW_WORD, REG_KEY_LOW, 64'h0, 4'd8, 1'b0, 1'b0, 64'h0},
    '{ROW_WORD, REG_KEY_LOW, 64'h8000000000000000, 4'd7, 1'b1, 1'b0, 64'h0},
    // config change with a message open: key held, round count taken
    '{ROW_WORD, REG_KEY_LOW, 64'h5555555555555555, 4'd8, 1'b0, 1'b0, 64'h0},
    '{ROW_REG, REG_KEY_LOW, 64'h0, 4'd0, 1'b0, 1'b0, 64'h0},
    '{ROW_REG, REG_COMP_ROUND, 64'h21, 4'd0, 1'b0, 1'b0, 64'h0},
    '{ROW_WORD, REG_KEY_LOW, 64'haaaaaaaaaaaaaaaa, 4'd4, 1'b1, 1'b0, 64'h0}
  };

  logic                 clk;
  logic                 rst;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [WORD_W-1:0]    cfg_data;

  sip_in_if  msg_if ();
  sip_out_if hash_if ();

  siphash_keyed_hash_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .msg_in    (msg_if),
    .hash_out  (hash_if),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // hash model state and its copy of the registers
  logic [WORD_W-1:0]  chain_v [4];
  logic [LEN_W-1:0]   len_acc;
  logic               in_message;
  logic [WORD_W-1:0]  k_lo;
  logic [WORD_W-1:0]  k_hi;
  logic [ROUND_W-1:0] c_rounds;
  logic [ROUND_W-1:0] d_rounds;

  logic [WORD_W-1:0] digest_q [$];

  int  mismatches    = 0;
  int  items_sent    = 0;
  int  next_gap      = 0;
  int  long_hold_req = 0;
  bit  valid_up      = 1'b0;
  bit  idle_on       = 1'b1;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #12_000_000;
    $display("siphash_keyed_hash_unit_tb NOT OK");
    $finish;
  end

  function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x, input int s);
    return (x << s) | (x >> (64 - s));
  endfunction

  function automatic int draw_wait();
    if (!idle_on || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, GAP_MAX);
  endfunction

  function automatic logic [WORD_W-1:0] rand_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return ONES;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                 input logic [WORD_W-1:0] want);
    $display("%0t: %s: got %h want %h", $realtime, what, got, want);
    mismatches++;
  endtask

  // xor in, rounds of SipRound, xor out
  task automatic absorb(input logic [WORD_W-1:0] m, input logic [ROUND_W-1:0] rounds);
    logic [WORD_W-1:0] va, vb, vc, vd;
    va = chain_v[0];
    vb = chain_v[1];
    vc = chain_v[2];
    vd = chain_v[3] ^ m;
    for (int i = 0; i < rounds; i++) begin
      va = va + vb; vb = rotl(vb, 13); vb = vb ^ va; va = rotl(va, 32);
      vc = vc + vd; vd = rotl(vd, 16); vd = vd ^ vc;
      va = va + vd; vd = rotl(vd, 21); vd = vd ^ va;
      vc = vc + vb; vb = rotl(vb, 17); vb = vb ^ vc; vc = rotl(vc, 32);
    end
    chain_v[0] = va ^ m;
    chain_v[1] = vb;
    chain_v[2] = vc;
    chain_v[3] = vd;
  endtask

  task automatic hash_word(input logic [WORD_W-1:0] data, input logic [COUNT_W-1:0] cnt,
                           input logic last, output logic has_digest,
                           output logic [WORD_W-1:0] digest);
    logic [WORD_W-1:0] pad;
    has_digest = 1'b0;
    digest = '0;
    if (!in_message) begin
      chain_v[0] = k_lo ^ SIP_C0;
      chain_v[1] = k_hi ^ SIP_C1;
      chain_v[2] = k_lo ^ SIP_C2;
      chain_v[3] = k_hi ^ SIP_C3;
      len_acc = '0;
      in_message = 1'b1;
    end
    if (!last) begin
      // short non-last words count as full
      absorb(data, c_rounds);
      len_acc = len_acc + 8'd8;
    end else begin
      if (cnt >= 8) begin
        absorb(data, c_rounds);
        len_acc = len_acc + 8'd8;
        pad = '0;
      end else begin
        pad = data & ((64'd1 << (8 * cnt)) - 64'd1);
        len_acc = len_acc + LEN_W'(cnt);
      end
      pad[63:56] = len_acc;
      absorb(pad, c_rounds);
      chain_v[2] = chain_v[2] ^ SIP_FIN_XOR;
      absorb('0, d_rounds);
      digest = chain_v[0] ^ chain_v[1] ^ chain_v[2] ^ chain_v[3];
      has_digest = 1'b1;
      in_message = 1'b0;
    end
  endtask

  task automatic send_word(input logic [WORD_W-1:0] data, input logic [COUNT_W-1:0] cnt,
                           input logic last, input logic known,
                           input logic [WORD_W-1:0] known_digest);
    logic              got;
    logic [WORD_W-1:0] pred;
    if (next_gap > 0) repeat (next_gap) @(posedge clk);
    msg_if.valid        <= 1'b1;
    msg_if.message_word <= data;
    msg_if.byte_count   <= cnt;
    msg_if.last_word    <= last;
    valid_up = 1'b1;
    do @(posedge clk); while (!msg_if.ready);
    hash_word(data, cnt, last, got, pred);
    if (got) digest_q.push_back(known ? known_digest : pred);
    items_sent++;
    // gap for the next word is drawn now so valid is only touched once per edge
    next_gap = draw_wait();
    if (next_gap > 0) begin
      msg_if.valid <= 1'b0;
      valid_up = 1'b0;
    end
  endtask

  task automatic wait_idle();
    if (valid_up) begin
      msg_if.valid <= 1'b0;
      valid_up = 1'b0;
    end
    while (digest_q.size() != 0) @(posedge clk);
    // non-last words may still be in the back end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_KEY_LOW:    k_lo = val;
      REG_KEY_HIGH:   k_hi = val;
      REG_COMP_ROUND: c_rounds = val[ROUND_W-1:0];
      REG_FIN_ROUND:  d_rounds = val[ROUND_W-1:0];
      default: ;
    endcase
  endtask

  function automatic logic [WORD_W-1:0] rand_rounds(input int typ_max);
    case ($urandom_range(0, 7))
      0: return 64'd0;
      1: return 64'd15;
      default: return WORD_W'($urandom_range(1, typ_max));
    endcase
  endfunction

  task automatic send_message(input bit close);
    int                 n;
    logic [COUNT_W-1:0] cnt;
    n = ($urandom_range(0, 11) == 0) ? $urandom_range(30, 40) : $urandom_range(0, 4);
    repeat (n) begin
      cnt = ($urandom_range(0, 3) == 0) ? COUNT_W'($urandom_range(0, 15)) : COUNT_W'(8);
      send_word(rand_word(), cnt, 1'b0, 1'b0, '0);
    end
    if (close) begin
      cnt = ($urandom_range(0, 4) == 0) ? COUNT_W'($urandom_range(8, 15))
                                        : COUNT_W'($urandom_range(0, 7));
      send_word(rand_word(), cnt, 1'b1, 1'b0, '0);
    end
  endtask

  // result side: random stalls, long hold on request, check against expected digests
  initial begin
    int                stall_left;
    logic [WORD_W-1:0] want;
    stall_left = 0;
    hash_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        stall_left = 0;
      end else begin
        if (hash_if.valid && hash_if.ready) begin
          if (digest_q.size() == 0) begin
            report_mismatch("unexpected digest", hash_if.digest, '0);
          end else begin
            want = digest_q.pop_front();
            if (hash_if.digest !== want) report_mismatch("digest", hash_if.digest, want);
          end
          stall_left = draw_wait();
        end else if (stall_left > 0) begin
          stall_left--;
        end
        if (long_hold_req != 0) begin
          stall_left = long_hold_req;
          long_hold_req = 0;
        end
      end
      hash_if.ready <= !rst && stall_left == 0;
    end
  end

  initial begin
    bit after_words;
    int phase;
    int n_msgs;
    rst                 = 1'b1;
    cfg_write           = 1'b0;
    cfg_index           = REG_KEY_LOW;
    cfg_data            = '0;
    msg_if.valid        = 1'b0;
    msg_if.message_word = '0;
    msg_if.byte_count   = '0;
    msg_if.last_word    = 1'b0;
    chain_v             = '{default: '0};
    len_acc             = '0;
    in_message          = 1'b0;
    k_lo                = '0;
    k_hi                = '0;
    c_rounds            = COMP_ROUNDS_RESET;
    d_rounds            = FIN_ROUNDS_RESET;
    after_words         = 1'b0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_REG) begin
        if (after_words) wait_idle();
        after_words = 1'b0;
        write_reg(directed[i].idx, directed[i].data);
      end else begin
        send_word(directed[i].data, directed[i].cnt, directed[i].last,
                  directed[i].known, directed[i].digest);
        after_words = 1'b1;
      end
    end

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      wait_idle();
      idle_on = ($urandom_range(0, 3) != 0);
      write_reg(REG_KEY_LOW, rand_word());
      write_reg(REG_KEY_HIGH, rand_word());
      write_reg(REG_COMP_ROUND, rand_rounds(4));
      write_reg(REG_FIN_ROUND, rand_rounds(6));
      if (phase == 2) begin
        // hold off the result side and keep pushing messages
        idle_on = 1'b0;
        long_hold_req = LONG_HOLD;
        repeat (12) send_message(1'b1);
        wait_idle();
        idle_on = 1'b1;
      end
      n_msgs = $urandom_range(3, 8);
      for (int m = 0; m < n_msgs; m++)
        send_message(!(phase % 4 == 3 && m == n_msgs - 1));
      phase++;
    end
    wait_idle();

    if (mismatches == 0 && digest_q.size() == 0) begin
      $display("siphash_keyed_hash_unit_tb OK");
    end else begin
      $display("siphash_keyed_hash_unit_tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/sip_pkg.sv
design/sip_if.sv
design/sip_front.sv
design/sip_fifo.sv
design/sip_back.sv
design/siphash_keyed_hash_unit.sv
design/sip_checker.sv
tb/siphash_keyed_hash_unit_tb.sv
